/* hw/rtl/shared_two_ended_list_store_core_macros.svh */
// assertion macros shared by the list store rtl
`ifndef SHARED_TWO_ENDED_LIST_STORE_CORE_MACROS_SVH
`define SHARED_TWO_ENDED_LIST_STORE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define STLSC_ASSERT_ALW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("stlsc check failed");

// same-cycle implication
`define STLSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stlsc check failed");

// next-cycle implication
`define STLSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stlsc check failed");

`else

`define STLSC_ASSERT_ALW(lbl, cond)
`define STLSC_ASSERT_IMP(lbl, ante, cons)
`define STLSC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* hw/rtl/stlsc_pkg.sv */
// shared types and constants of the list store
package stlsc_pkg;

  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int REG_COUNT  = 3;
  localparam int HANDLE_W   = 16;
  localparam int REQ_W      = 2;
  localparam int LSEL_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int OUT_CNT_W  = 9;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_OBJ  = 2'd0,
    REQ_REM_OBJ   = 2'd1,
    REQ_PUSH_PRIM = 2'd2,
    REQ_REM_PRIM  = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAP_LIST0 = 2'd0,
    REG_CAP_LIST1 = 2'd1,
    REG_CAP_LIST2 = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHIFT,
    S_FIN
  } ctrl_state_t;

  // capacity of each list after reset, before saturation to the list depth
  function automatic logic [CFG_W-1:0] cap_reset_val(int l);
    logic [CFG_W-1:0] v;
    case (l)
      0: v = 9'd8;
      1: v = 9'd256;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/stlsc_req_if.sv */
// request channel: valid/ready with request payload
interface stlsc_req_if import stlsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [LSEL_W-1:0]   list_sel;
  logic [HANDLE_W-1:0] item_handle;

  modport source (output valid, req_type, list_sel, item_handle, input ready);
  modport sink   (input valid, req_type, list_sel, item_handle, output ready);
endinterface

/* hw/rtl/stlsc_rsp_if.sv */
// result channel: valid/ready with result payload
interface stlsc_rsp_if import stlsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [OUT_CNT_W-1:0] object_count;
  logic [OUT_CNT_W-1:0] primitive_boundary;

  modport source (output valid, status, object_count, primitive_boundary, input ready);
  modport sink   (input valid, status, object_count, primitive_boundary, output ready);
endinterface

/* hw/rtl/stlsc_ram.sv */
// generic single-clock ram, one write port, one registered read port
module stlsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/stlsc_lists.sv */
// per-list capacity, object count and primitive boundary registers
`include "shared_two_ended_list_store_core_macros.svh"

module stlsc_lists import stlsc_pkg::*; #(
  parameter int LIST_COUNT = 3,
  parameter int LIST_DEPTH = 256,
  localparam int LIST_W    = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1,
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [LIST_W-1:0]    rd_list,
  output logic [CNT_W-1:0]     rd_cap,
  output logic [CNT_W-1:0]     rd_cnt,
  output logic [CNT_W-1:0]     rd_bnd,
  input  logic                 upd_en,
  input  logic [LIST_W-1:0]    upd_list,
  input  logic [CNT_W-1:0]     upd_cnt,
  input  logic [CNT_W-1:0]     upd_bnd
);

  logic [CNT_W-1:0] cap_r [LIST_COUNT];
  logic [CNT_W-1:0] cnt_r [LIST_COUNT];
  logic [CNT_W-1:0] bnd_r [LIST_COUNT];
  logic             cfg_hit;
  logic [LIST_W-1:0] cfg_list;
  logic [CNT_W-1:0] cfg_cap;
  logic             rd_ok;

  // saturate a written capacity to the list depth
  function automatic logic [CNT_W-1:0] clamp_cap(logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (32'(v) > LIST_DEPTH) begin
      r = CNT_W'(LIST_DEPTH);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  assign cfg_hit  = cfg_we && (32'(cfg_idx) < REG_COUNT) && (32'(cfg_idx) < LIST_COUNT);
  assign cfg_list = LIST_W'(cfg_idx);
  assign cfg_cap  = clamp_cap(cfg_data);
  assign rd_ok    = 32'(rd_list) < LIST_COUNT;

  always_comb begin
    rd_cap = '0;
    rd_cnt = '0;
    rd_bnd = '0;
    if (rd_ok) begin
      rd_cap = cap_r[rd_list];
      rd_cnt = cnt_r[rd_list];
      rd_bnd = bnd_r[rd_list];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LIST_COUNT; l++) begin
        cap_r[l] <= clamp_cap(cap_reset_val(l));
        cnt_r[l] <= '0;
        bnd_r[l] <= clamp_cap(cap_reset_val(l));
      end
    end else begin
      // a capacity write empties its list
      if (cfg_hit) begin
        cap_r[cfg_list] <= cfg_cap;
        cnt_r[cfg_list] <= '0;
        bnd_r[cfg_list] <= cfg_cap;
      end else if (upd_en) begin
        cnt_r[upd_list] <= upd_cnt;
        bnd_r[upd_list] <= upd_bnd;
      end
    end
  end

  `STLSC_ASSERT_ALW(a_l0_order, cnt_r[0] <= bnd_r[0])
  `STLSC_ASSERT_ALW(a_l0_cap, bnd_r[0] <= cap_r[0] && 32'(cap_r[0]) <= LIST_DEPTH)
  `STLSC_ASSERT_NXT(a_cfg_empties, cfg_we && cfg_idx == REG_CAP_LIST0, cnt_r[0] == '0)

endmodule

/* hw/rtl/stlsc_seq.sv */
// request sequencer: push, search and compaction over the handle ram
`include "shared_two_ended_list_store_core_macros.svh"

module stlsc_seq import stlsc_pkg::*; #(
  parameter int LIST_COUNT = 3,
  parameter int LIST_DEPTH = 256,
  localparam int LIST_W    = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1,
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1),
  localparam int IDX_W     = $clog2(LIST_DEPTH),
  localparam int ADDR_W    = $clog2(LIST_COUNT * LIST_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  stlsc_req_if.sink           in_req,
  stlsc_rsp_if.source         out_rsp,
  output logic [LIST_W-1:0]   rd_list,
  input  logic [CNT_W-1:0]    rd_cap,
  input  logic [CNT_W-1:0]    rd_cnt,
  input  logic [CNT_W-1:0]    rd_bnd,
  output logic                upd_en,
  output logic [LIST_W-1:0]   upd_list,
  output logic [CNT_W-1:0]    upd_cnt,
  output logic [CNT_W-1:0]    upd_bnd,
  output logic                ram_we,
  output logic [ADDR_W-1:0]   ram_waddr,
  output logic [HANDLE_W-1:0] ram_wdata,
  output logic                ram_re,
  output logic [ADDR_W-1:0]   ram_raddr,
  input  logic [HANDLE_W-1:0] ram_rdata
);

  ctrl_state_t          state_r, state_nxt;
  req_type_t            req_r, req_nxt;
  logic [LIST_W-1:0]    list_r, list_nxt;
  logic [HANDLE_W-1:0]  hnd_r, hnd_nxt;
  logic                 inr_r, inr_nxt;
  status_t              status_r, status_nxt;
  logic [CNT_W-1:0]     wk_cnt_r, wk_cnt_nxt;
  logic [CNT_W-1:0]     wk_bnd_r, wk_bnd_nxt;
  logic [IDX_W-1:0]     rp_r, rp_nxt;
  logic [IDX_W-1:0]     dp_r, dp_nxt;
  logic [IDX_W-1:0]     end_r, end_nxt;
  logic                 rd_more_r, rd_more_nxt;
  logic                 dv_r, dv_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [OUT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [OUT_CNT_W-1:0] out_bnd_r, out_bnd_nxt;

  logic acc;
  logic out_free;
  logic dir_up;
  logic hit;
  logic at_end;

  function automatic logic [ADDR_W-1:0] mk_addr(logic [LIST_W-1:0] l, logic [IDX_W-1:0] i);
    return ADDR_W'(ADDR_W'(l) * ADDR_W'(LIST_DEPTH) + ADDR_W'(i));
  endfunction

  assign in_req.ready = (state_r == S_IDLE);
  assign acc          = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign dir_up       = (req_r == REQ_REM_OBJ);
  assign hit          = dv_r && (ram_rdata == hnd_r);
  assign at_end       = dv_r && (dp_r == end_r);

  assign rd_list  = list_r;
  assign upd_list = list_r;
  assign upd_cnt  = wk_cnt_r;
  assign upd_bnd  = wk_bnd_r;

  assign out_rsp.valid              = out_valid_r;
  assign out_rsp.status             = out_status_r;
  assign out_rsp.object_count       = out_cnt_r;
  assign out_rsp.primitive_boundary = out_bnd_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (inr_r && ((req_r == REQ_REM_OBJ && rd_cnt != '0) ||
                      (req_r == REQ_REM_PRIM && rd_bnd != rd_cap))) begin
          state_nxt = S_SEARCH;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SEARCH: begin
        if (at_end) begin
          state_nxt = S_FIN;
        end else if (hit) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (at_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt        = req_r;
    list_nxt       = list_r;
    hnd_nxt        = hnd_r;
    inr_nxt        = inr_r;
    status_nxt     = status_r;
    wk_cnt_nxt     = wk_cnt_r;
    wk_bnd_nxt     = wk_bnd_r;
    rp_nxt         = rp_r;
    dp_nxt         = dp_r;
    end_nxt        = end_r;
    rd_more_nxt    = rd_more_r;
    dv_nxt         = dv_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    out_bnd_nxt    = out_bnd_r;
    upd_en         = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = mk_addr(list_r, dp_r);
    ram_wdata      = hnd_r;
    ram_re         = 1'b0;
    ram_raddr      = mk_addr(list_r, rp_r);
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          req_nxt  = req_type_t'(in_req.req_type);
          list_nxt = LIST_W'(in_req.list_sel);
          hnd_nxt  = in_req.item_handle;
          inr_nxt  = 32'(in_req.list_sel) < LIST_COUNT;
        end
      end
      S_EXEC: begin
        wk_cnt_nxt  = rd_cnt;
        wk_bnd_nxt  = rd_bnd;
        status_nxt  = ST_OK;
        dv_nxt      = 1'b0;
        rd_more_nxt = 1'b0;
        if (!inr_r) begin
          // no such list: behaves as an empty list of capacity zero
          status_nxt = req_r[0] ? ST_NOT_FOUND : ST_FULL;
          wk_cnt_nxt = '0;
          wk_bnd_nxt = '0;
        end else begin
          case (req_r)
            REQ_PUSH_OBJ: begin
              if (rd_cnt >= rd_bnd) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = mk_addr(list_r, IDX_W'(rd_cnt));
                wk_cnt_nxt = CNT_W'(rd_cnt + 1'b1);
              end
            end
            REQ_PUSH_PRIM: begin
              if (rd_bnd <= rd_cnt) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = mk_addr(list_r, IDX_W'(rd_bnd - 1'b1));
                wk_bnd_nxt = CNT_W'(rd_bnd - 1'b1);
              end
            end
            REQ_REM_OBJ: begin
              if (rd_cnt == '0) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                rp_nxt      = '0;
                end_nxt     = IDX_W'(rd_cnt - 1'b1);
                rd_more_nxt = 1'b1;
              end
            end
            REQ_REM_PRIM: begin
              if (rd_bnd == rd_cap) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                rp_nxt      = IDX_W'(rd_cap - 1'b1);
                end_nxt     = IDX_W'(rd_bnd);
                rd_more_nxt = 1'b1;
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      S_SEARCH, S_SHIFT: begin
        // one read issued per cycle, compared or moved in the next cycle
        ram_re = rd_more_r;
        dv_nxt = rd_more_r;
        dp_nxt = rp_r;
        if (rd_more_r) begin
          if (rp_r == end_r) begin
            rd_more_nxt = 1'b0;
          end else if (dir_up) begin
            rp_nxt = IDX_W'(rp_r + 1'b1);
          end else begin
            rp_nxt = IDX_W'(rp_r - 1'b1);
          end
        end
        if (state_r == S_SEARCH) begin
          if (at_end && !hit) begin
            status_nxt = ST_NOT_FOUND;
          end else if (at_end) begin
            if (dir_up) begin
              wk_cnt_nxt = CNT_W'(wk_cnt_r - 1'b1);
            end else begin
              wk_bnd_nxt = CNT_W'(wk_bnd_r + 1'b1);
            end
          end
        end else if (dv_r) begin
          // close the gap: each entry moves one slot toward the match
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          if (dir_up) begin
            ram_waddr = mk_addr(list_r, IDX_W'(dp_r - 1'b1));
          end else begin
            ram_waddr = mk_addr(list_r, IDX_W'(dp_r + 1'b1));
          end
          if (at_end) begin
            if (dir_up) begin
              wk_cnt_nxt = CNT_W'(wk_cnt_r - 1'b1);
            end else begin
              wk_bnd_nxt = CNT_W'(wk_bnd_r + 1'b1);
            end
          end
        end
      end
      S_FIN: begin
        upd_en = inr_r;
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_cnt_nxt    = OUT_CNT_W'(wk_cnt_r);
          out_bnd_nxt    = OUT_CNT_W'(wk_bnd_r);
        end
      end
      default: begin
        rd_more_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_more_r   <= 1'b0;
      dv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_more_r   <= rd_more_nxt;
      dv_r        <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    list_r       <= list_nxt;
    hnd_r        <= hnd_nxt;
    inr_r        <= inr_nxt;
    status_r     <= status_nxt;
    wk_cnt_r     <= wk_cnt_nxt;
    wk_bnd_r     <= wk_bnd_nxt;
    rp_r         <= rp_nxt;
    dp_r         <= dp_nxt;
    end_r        <= end_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_bnd_r    <= out_bnd_nxt;
  end

  `STLSC_ASSERT_IMP(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr)
  `STLSC_ASSERT_IMP(a_we_phase, ram_we, state_r == S_EXEC || state_r == S_SHIFT)
  `STLSC_ASSERT_NXT(a_accept_exec, in_req.valid && in_req.ready, state_r == S_EXEC)
  `STLSC_ASSERT_IMP(a_shift_fed, state_r == S_SHIFT, dv_r)

endmodule

/* hw/rtl/shared_two_ended_list_store_core.sv */
// top level of the shared two-ended list store
//
// Each list owns LIST_DEPTH handle slots in one shared ram; objects stack up
// from slot 0 and primitives stack down from the list's capacity. One request
// is handled at a time. A push latches the request, writes the ram and then
// registers the result. A removal walks the ram one entry per cycle through
// its single read port: a search to the first match is followed by a
// compaction over the entries behind it, and a missing handle is searched
// for over the full stack length. The result register lets the next request
// transfer in while the previous result still waits. Capacity writes empty
// the addressed list; they are only legal while no request is in flight. The
// handle ram is not cleared after reset: only live entries are ever read.

module shared_two_ended_list_store_core import stlsc_pkg::*; #(
  parameter int LIST_COUNT = 3,
  parameter int LIST_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  stlsc_req_if.sink            in_req,
  stlsc_rsp_if.source          out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int LIST_W = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = $clog2(LIST_COUNT * LIST_DEPTH);

  // list register file read/update
  logic [LIST_W-1:0]   rd_list;
  logic [CNT_W-1:0]    rd_cap;
  logic [CNT_W-1:0]    rd_cnt;
  logic [CNT_W-1:0]    rd_bnd;
  logic                upd_en;
  logic [LIST_W-1:0]   upd_list;
  logic [CNT_W-1:0]    upd_cnt;
  logic [CNT_W-1:0]    upd_bnd;

  // handle ram ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [HANDLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [HANDLE_W-1:0] ram_rdata;

  // boundaries and capacities of all lists
  stlsc_lists #(
    .LIST_COUNT (LIST_COUNT),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_lists (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .rd_list  (rd_list),
    .rd_cap   (rd_cap),
    .rd_cnt   (rd_cnt),
    .rd_bnd   (rd_bnd),
    .upd_en   (upd_en),
    .upd_list (upd_list),
    .upd_cnt  (upd_cnt),
    .upd_bnd  (upd_bnd)
  );

  // request sequencer with result register
  stlsc_seq #(
    .LIST_COUNT (LIST_COUNT),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .rd_list   (rd_list),
    .rd_cap    (rd_cap),
    .rd_cnt    (rd_cnt),
    .rd_bnd    (rd_bnd),
    .upd_en    (upd_en),
    .upd_list  (upd_list),
    .upd_cnt   (upd_cnt),
    .upd_bnd   (upd_bnd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // handle store, one row of LIST_DEPTH slots per list
  stlsc_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (LIST_COUNT * LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
